FILE: hw/rtl/oggphp_pkg.sv
// Shared types, constants and helpers for the Ogg page header parser.
package oggphp_pkg;

   localparam int POSITION_BITS = 48;
   localparam int OUT_POS_BITS  = 48;
   localparam int FIFO_DEPTH    = 4;
   localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
   localparam int LEVEL_BITS    = $clog2(FIFO_DEPTH + 1);

   localparam logic [2:0] KIND_PAGE         = 3'd0;
   localparam logic [2:0] KIND_PACKET       = 3'd1;
   localparam logic [2:0] KIND_BAD_CAPTURE  = 3'd2;
   localparam logic [2:0] KIND_ZERO_SEGS    = 3'd3;
   localparam logic [2:0] KIND_BAD_SEQUENCE = 3'd4;
   localparam logic [2:0] KIND_BAD_CONT     = 3'd5;
   localparam logic [2:0] KIND_GRANULE      = 3'd6;

   localparam logic [7:0] LACING_MAX = 8'd255;

   typedef struct packed {
      logic [2:0]              kind;
      logic [63:0]             granule;
      logic [31:0]             serial_number;
      logic [31:0]             sequence_number;
      logic [31:0]             page_crc;
      logic [7:0]              header_flags;
      logic                    page_done;
      logic [OUT_POS_BITS-1:0] packet_position;
      logic [15:0]             packet_length;
      logic                    packet_open;
      logic                    last;
   } result_type;

   // Up to two results are written into the output queue per byte.
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

   function automatic logic [7:0] capture_byte(input logic [1:0] sel);
      logic [7:0] val;
      unique case (sel)
         2'd0: val = 8'h4F;
         2'd1: val = 8'h67;
         2'd2: val = 8'h67;
         default: val = 8'h53;
      endcase
      return val;
   endfunction

   function automatic logic [OUT_POS_BITS-1:0] out_position(
      input logic [POSITION_BITS-1:0] pos);
      logic [63:0] wide;
      wide = 64'(pos);
      return wide[OUT_POS_BITS-1:0];
   endfunction

endpackage

FILE: hw/rtl/oggphp_parser.sv
// Byte-wise page parser: capture check, header fields, lacing table and payload skip.
module oggphp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          stream_byte,
   output oggphp_pkg::push_type push
);
   import oggphp_pkg::*;

   localparam logic [3:0] PH_CAP0    = 4'd0;
   localparam logic [3:0] PH_VERSION = 4'd4;
   localparam logic [3:0] PH_TYPE    = 4'd5;
   localparam logic [3:0] PH_GRANULE = 4'd6;
   localparam logic [3:0] PH_SERIAL  = 4'd7;
   localparam logic [3:0] PH_SEQ     = 4'd8;
   localparam logic [3:0] PH_CRC     = 4'd9;
   localparam logic [3:0] PH_COUNT   = 4'd10;
   localparam logic [3:0] PH_TABLE   = 4'd11;
   localparam logic [3:0] PH_SKIP    = 4'd12;

   logic [3:0]               phase_ff, phase_in;
   logic [2:0]               idx_ff, idx_in;
   logic [63:0]              shift_ff, shift_in;
   logic [7:0]               hdr_ff, hdr_in;
   logic [63:0]              granule_ff, granule_in;
   logic [31:0]              serial_ff, serial_in;
   logic [31:0]              seq_ff, seq_in;
   logic [31:0]              crc_ff, crc_in;
   logic [7:0]               seg_ff, seg_in;
   logic [16:0]              run_ff, run_in;
   logic [16:0]              poff_ff, poff_in;
   logic [16:0]              skip_ff, skip_in;
   logic [POSITION_BITS-1:0] spos_ff, spos_in;
   logic [31:0]              expseq_ff, expseq_in;
   logic                     pending_ff, pending_in;
   logic                     completed_ff, completed_in;
   logic                     halted_ff, halted_in;

   result_type               base;
   logic                     do_clear;
   logic [63:0]              shift_full;
   logic                     field_end;
   logic                     is_open;
   logic [16:0]              run_new;
   logic [16:0]              poff_new;
   logic [7:0]               seg_dec;
   logic                     run_end;
   logic                     completed_new;
   logic                     granule_ok;
   logic [POSITION_BITS-1:0] pos_calc;
   logic [16:0]              skip_dec;

   always_comb begin
      base                 = '0;
      base.granule         = granule_ff;
      base.serial_number   = serial_ff;
      base.sequence_number = seq_ff;
      base.page_crc        = crc_ff;
      base.header_flags    = hdr_ff;

      shift_full    = shift_ff | (64'(stream_byte) << {idx_ff, 3'b000});
      field_end     = (phase_ff == PH_GRANULE) ? (idx_ff == 3'd7) : (idx_ff == 3'd3);
      is_open       = (stream_byte == LACING_MAX);
      run_new       = run_ff + 17'(stream_byte);
      seg_dec       = (seg_ff != 8'd0) ? seg_ff - 8'd1 : seg_ff;
      run_end       = !is_open || (seg_dec == 8'd0);
      poff_new      = run_end ? poff_ff + run_new : poff_ff;
      completed_new = completed_ff | (run_end & !is_open);
      granule_ok    = granule_ff[63] ? is_open : completed_new;
      pos_calc      = spos_ff + POSITION_BITS'(1) + POSITION_BITS'(seg_dec)
                      + POSITION_BITS'(poff_ff);
      skip_dec      = (skip_ff != 17'd0) ? skip_ff - 17'd1 : skip_ff;

      phase_in     = phase_ff;
      idx_in       = idx_ff;
      shift_in     = shift_ff;
      hdr_in       = hdr_ff;
      granule_in   = granule_ff;
      serial_in    = serial_ff;
      seq_in       = seq_ff;
      crc_in       = crc_ff;
      seg_in       = seg_ff;
      run_in       = run_ff;
      poff_in      = poff_ff;
      skip_in      = skip_ff;
      spos_in      = spos_ff;
      expseq_in    = expseq_ff;
      pending_in   = pending_ff;
      completed_in = completed_ff;
      halted_in    = halted_ff;
      do_clear     = 1'b0;

      push       = '0;
      push.res0  = base;
      push.res1  = base;

      if (accept && !halted_ff) begin
         spos_in = spos_ff + POSITION_BITS'(1);
         priority if (phase_ff < PH_VERSION) begin
            if (stream_byte != capture_byte(phase_ff[1:0])) begin
               push.count     = 2'd1;
               push.res0.kind = KIND_BAD_CAPTURE;
               halted_in      = 1'b1;
            end else begin
               phase_in = phase_ff + 4'd1;
            end
         end else if (phase_ff == PH_VERSION) begin
            phase_in = PH_TYPE;
         end else if (phase_ff == PH_TYPE) begin
            hdr_in   = stream_byte;
            phase_in = PH_GRANULE;
            idx_in   = 3'd0;
            shift_in = '0;
         end else if (phase_ff <= PH_CRC) begin
            if (field_end) begin
               unique case (phase_ff)
                  PH_GRANULE: granule_in = shift_full;
                  PH_SERIAL:  serial_in  = shift_full[31:0];
                  PH_SEQ:     seq_in     = shift_full[31:0];
                  default:    crc_in     = shift_full[31:0];
               endcase
               phase_in = phase_ff + 4'd1;
               idx_in   = 3'd0;
               shift_in = '0;
            end else begin
               shift_in = shift_full;
               idx_in   = idx_ff + 3'd1;
            end
         end else if (phase_ff == PH_COUNT) begin
            priority if (stream_byte == 8'd0) begin
               push.count     = 2'd1;
               push.res0.kind = KIND_ZERO_SEGS;
               halted_in      = 1'b1;
            end else if (seq_ff != expseq_ff) begin
               push.count     = 2'd1;
               push.res0.kind = KIND_BAD_SEQUENCE;
               halted_in      = 1'b1;
            end else if (hdr_ff[0] != pending_ff) begin
               push.count     = 2'd1;
               push.res0.kind = KIND_BAD_CONT;
               halted_in      = 1'b1;
            end else begin
               expseq_in    = expseq_ff + 32'd1;
               seg_in       = stream_byte;
               run_in       = '0;
               poff_in      = '0;
               completed_in = 1'b0;
               phase_in     = PH_TABLE;
            end
         end else if (phase_ff == PH_TABLE) begin
            seg_in       = seg_dec;
            completed_in = completed_new;
            poff_in      = poff_new;
            run_in       = run_end ? 17'd0 : run_new;
            if (run_end) begin
               push.count                = 2'd1;
               push.res0.kind            = KIND_PACKET;
               push.res0.packet_position = out_position(pos_calc);
               push.res0.packet_length   = run_new[15:0];
               push.res0.packet_open     = is_open;
            end
            if (seg_dec == 8'd0) begin
               // The last table byte always ends a run, so this is the second result.
               push.count = 2'd2;
               if (!granule_ok) begin
                  push.res1.kind = KIND_GRANULE;
                  halted_in      = 1'b1;
               end else begin
                  push.res1.kind      = KIND_PAGE;
                  push.res1.page_done = !is_open;
                  pending_in          = is_open;
                  if (poff_new != 17'd0) begin
                     skip_in  = poff_new;
                     phase_in = PH_SKIP;
                  end else begin
                     do_clear = 1'b1;
                  end
               end
            end
         end else begin
            skip_in = skip_dec;
            if (skip_dec == 17'd0) begin
               do_clear = 1'b1;
            end
         end
      end

      if (do_clear) begin
         phase_in     = PH_CAP0;
         idx_in       = '0;
         shift_in     = '0;
         hdr_in       = '0;
         granule_in   = '0;
         serial_in    = '0;
         seq_in       = '0;
         crc_in       = '0;
         seg_in       = '0;
         run_in       = '0;
         poff_in      = '0;
         skip_in      = '0;
         completed_in = 1'b0;
      end

      if (push.count == 2'd1) begin
         push.res0.last = 1'b1;
      end
      if (push.count == 2'd2) begin
         push.res1.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CAP0;
         idx_ff       <= '0;
         shift_ff     <= '0;
         hdr_ff       <= '0;
         granule_ff   <= '0;
         serial_ff    <= '0;
         seq_ff       <= '0;
         crc_ff       <= '0;
         seg_ff       <= '0;
         run_ff       <= '0;
         poff_ff      <= '0;
         skip_ff      <= '0;
         spos_ff      <= '0;
         expseq_ff    <= '0;
         pending_ff   <= 1'b0;
         completed_ff <= 1'b0;
         halted_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         shift_ff     <= shift_in;
         hdr_ff       <= hdr_in;
         granule_ff   <= granule_in;
         serial_ff    <= serial_in;
         seq_ff       <= seq_in;
         crc_ff       <= crc_in;
         seg_ff       <= seg_in;
         run_ff       <= run_in;
         poff_ff      <= poff_in;
         skip_ff      <= skip_in;
         spos_ff      <= spos_in;
         expseq_ff    <= expseq_in;
         pending_ff   <= pending_in;
         completed_ff <= completed_in;
         halted_ff    <= halted_in;
      end
   end

endmodule

FILE: hw/rtl/oggphp_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one.
module oggphp_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  oggphp_pkg::push_type                 push,
   input  logic                                 pop,
   output logic                                 out_valid,
   output oggphp_pkg::result_type               out_data,
   output logic [oggphp_pkg::LEVEL_BITS-1:0]    level
);
   import oggphp_pkg::*;

   result_type          entries_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [PTR_BITS-1:0] wr_ptr_next;
   logic                do_pop;

   assign out_valid = (level_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_next = wr_ptr_ff + PTR_BITS'(1);
      wr_ptr_in   = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in   = rd_ptr_ff + PTR_BITS'(do_pop);
      level_in    = level_ff + LEVEL_BITS'(push.count) - LEVEL_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_next] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

FILE: hw/rtl/ogg_page_header_parser_top.sv
// Top level of the Ogg page header parser: byte input, result queue output.
//
//   channel | direction | ports                         | carries
//   req     | in        | req_valid/ready, stream_byte  | one stream byte per transfer
//   rsp     | out       | rsp_valid/ready, result ports | one page, packet or error result
//
// Each byte is parsed in the cycle it is accepted; its zero, one or two results are
// written into a four-entry queue and can leave on the next cycle.
// One byte per cycle is taken while at least two queue entries are free, so a
// stalled result side blocks input once the queue holds three or more results.
// A byte that yields two results hands them out of the queue one after the other.
// Reset is synchronous and empties the queue; after an error the block keeps
// taking bytes but produces nothing until reset.
module ogg_page_header_parser_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [7:0]                               req_stream_byte,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [2:0]                               rsp_kind,
   output logic signed [63:0]                       rsp_granule,
   output logic [31:0]                              rsp_serial_number,
   output logic [31:0]                              rsp_sequence_number,
   output logic [31:0]                              rsp_page_crc,
   output logic [7:0]                               rsp_header_flags,
   output logic                                     rsp_page_done,
   output logic [oggphp_pkg::OUT_POS_BITS-1:0]      rsp_packet_position,
   output logic [15:0]                              rsp_packet_length,
   output logic                                     rsp_packet_open,
   output logic                                     rsp_last
);
   import oggphp_pkg::*;

   push_type              push;
   result_type            head;
   logic [LEVEL_BITS-1:0] level;
   logic                  req_accept;

   assign req_ready  = (level <= LEVEL_BITS'(FIFO_DEPTH - 2));
   assign req_accept = req_valid && req_ready;

   oggphp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .stream_byte (req_stream_byte),
      .push        (push)
   );

   oggphp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (head),
      .level     (level)
   );

   assign rsp_kind            = head.kind;
   assign rsp_granule         = $signed(head.granule);
   assign rsp_serial_number   = head.serial_number;
   assign rsp_sequence_number = head.sequence_number;
   assign rsp_page_crc        = head.page_crc;
   assign rsp_header_flags    = head.header_flags;
   assign rsp_page_done       = head.page_done;
   assign rsp_packet_position = head.packet_position;
   assign rsp_packet_length   = head.packet_length;
   assign rsp_packet_open     = head.packet_open;
   assign rsp_last            = head.last;

   // The queue never holds more results than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      level <= LEVEL_BITS'(FIFO_DEPTH))
      else $error("result queue overflow");

   // Only a page header result carries the completion flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_PAGE) |-> !rsp_page_done)
      else $error("page_done set outside a page header");

   // Descriptor values are zero in every result that is not a descriptor.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_PACKET) |->
         (rsp_packet_length == 16'd0) && !rsp_packet_open && (rsp_packet_position == '0))
      else $error("descriptor fields set outside a descriptor");

   // An error is always the final result of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_PAGE) && (rsp_kind != KIND_PACKET) |-> rsp_last)
      else $error("error result not marked last");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the Ogg page header parser top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import oggphp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 50;
   localparam logic [7:0] SYNC_BYTES [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};
   localparam logic [2:0] FAULT_KINDS [5] = '{KIND_BAD_CAPTURE, KIND_ZERO_SEGS,
      KIND_BAD_SEQUENCE, KIND_BAD_CONT, KIND_GRANULE};

   typedef enum logic [3:0] {
      PH_CAP0, PH_CAP1, PH_CAP2, PH_CAP3, PH_VERSION, PH_TYPE, PH_GRANULE,
      PH_SERIAL, PH_SEQ, PH_CRC, PH_COUNT, PH_TABLE, PH_SKIP
   } parse_phase_type;

   typedef logic [7:0] lacing_list_type[$];

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [7:0]              req_stream_byte = 8'd0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [2:0]              rsp_kind;
   logic signed [63:0]      rsp_granule;
   logic [31:0]             rsp_serial_number;
   logic [31:0]             rsp_sequence_number;
   logic [31:0]             rsp_page_crc;
   logic [7:0]              rsp_header_flags;
   logic                    rsp_page_done;
   logic [OUT_POS_BITS-1:0] rsp_packet_position;
   logic [15:0]             rsp_packet_length;
   logic                    rsp_packet_open;
   logic                    rsp_last;

   ogg_page_header_parser_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_stream_byte     (req_stream_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_granule         (rsp_granule),
      .rsp_serial_number   (rsp_serial_number),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_page_crc        (rsp_page_crc),
      .rsp_header_flags    (rsp_header_flags),
      .rsp_page_done       (rsp_page_done),
      .rsp_packet_position (rsp_packet_position),
      .rsp_packet_length   (rsp_packet_length),
      .rsp_packet_open     (rsp_packet_open),
      .rsp_last            (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Parser state mirrored for prediction.
   parse_phase_type          ps_phase;
   logic [2:0]               ps_field_idx;
   logic [63:0]              ps_shift;
   logic [7:0]               ps_flags;
   logic [63:0]              ps_granule;
   logic [31:0]              ps_serial;
   logic [31:0]              ps_sequence;
   logic [31:0]              ps_crc;
   logic [7:0]               ps_segs_left;
   logic [16:0]              ps_run;
   logic [16:0]              ps_payload;
   logic [16:0]              ps_skip;
   logic [POSITION_BITS-1:0] ps_position;
   logic [31:0]              ps_next_seq;
   logic                     ps_open_packet;
   logic                     ps_completed;
   logic                     ps_halted;

   result_type  expected_results[$];
   logic [7:0]  pending_bytes[$];
   logic [31:0] gen_sequence = 32'd0;
   logic        gen_open = 1'b0;
   logic [2:0]  fault_kind = KIND_PAGE;
   int unsigned bytes_queued = 0;
   int unsigned bytes_accepted = 0;
   int unsigned pages_seen = 0;
   int unsigned packets_seen = 0;
   int unsigned faults_seen = 0;
   int unsigned failures = 0;
   int unsigned quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   function automatic void clear_page_state();
      ps_phase     = PH_CAP0;
      ps_field_idx = '0;
      ps_shift     = '0;
      ps_flags     = '0;
      ps_granule   = '0;
      ps_serial    = '0;
      ps_sequence  = '0;
      ps_crc       = '0;
      ps_segs_left = '0;
      ps_run       = '0;
      ps_payload   = '0;
      ps_skip      = '0;
      ps_completed = 1'b0;
   endfunction

   function automatic void reset_parser_state();
      clear_page_state();
      ps_position    = '0;
      ps_next_seq    = '0;
      ps_open_packet = 1'b0;
      ps_halted      = 1'b0;
   endfunction

   function automatic void push_result(logic [2:0] kind, logic done,
                                       logic [OUT_POS_BITS-1:0] pos,
                                       logic [15:0] len, logic open);
      result_type r;
      r                 = '0;
      r.kind            = kind;
      r.granule         = ps_granule;
      r.serial_number   = ps_serial;
      r.sequence_number = ps_sequence;
      r.page_crc        = ps_crc;
      r.header_flags    = ps_flags;
      r.page_done       = done;
      r.packet_position = pos;
      r.packet_length   = len;
      r.packet_open     = open;
      expected_results.insert(expected_results.size(), r);
   endfunction

   // Advances the mirrored parser by one stream byte and queues its results.
   function automatic void parse_byte(logic [7:0] b);
      logic [POSITION_BITS-1:0] here;
      logic [POSITION_BITS-1:0] wrapped;
      logic [63:0]              pos;
      int                       before_count;
      int                       field_len;
      logic                     lace_open;
      logic                     ok;
      if (ps_halted)
         return;
      here = ps_position;
      before_count = expected_results.size();
      ps_position = ps_position + POSITION_BITS'(1);

      if (ps_phase < PH_VERSION) begin
         if (b != SYNC_BYTES[int'(ps_phase)]) begin
            push_result(KIND_BAD_CAPTURE, 1'b0, '0, '0, 1'b0);
            ps_halted = 1'b1;
         end else begin
            ps_phase = parse_phase_type'(ps_phase + 4'd1);
         end
      end else if (ps_phase == PH_VERSION) begin
         ps_phase = PH_TYPE;
      end else if (ps_phase == PH_TYPE) begin
         ps_flags     = b;
         ps_phase     = PH_GRANULE;
         ps_field_idx = '0;
         ps_shift     = '0;
      end else if (ps_phase >= PH_GRANULE && ps_phase <= PH_CRC) begin
         field_len = (ps_phase == PH_GRANULE) ? 8 : 4;
         ps_shift = ps_shift | (64'(b) << (8 * ps_field_idx));
         if (int'(ps_field_idx) + 1 >= field_len) begin
            case (ps_phase)
               PH_GRANULE: ps_granule = ps_shift;
               PH_SERIAL: ps_serial = ps_shift[31:0];
               PH_SEQ: ps_sequence = ps_shift[31:0];
               default: ps_crc = ps_shift[31:0];
            endcase
            ps_phase     = parse_phase_type'(ps_phase + 4'd1);
            ps_field_idx = '0;
            ps_shift     = '0;
         end else begin
            ps_field_idx = ps_field_idx + 3'd1;
         end
      end else if (ps_phase == PH_COUNT) begin
         if (b == 8'd0) begin
            push_result(KIND_ZERO_SEGS, 1'b0, '0, '0, 1'b0);
            ps_halted = 1'b1;
         end else if (ps_sequence != ps_next_seq) begin
            push_result(KIND_BAD_SEQUENCE, 1'b0, '0, '0, 1'b0);
            ps_halted = 1'b1;
         end else if (ps_flags[0] != ps_open_packet) begin
            push_result(KIND_BAD_CONT, 1'b0, '0, '0, 1'b0);
            ps_halted = 1'b1;
         end else begin
            ps_next_seq  = ps_next_seq + 32'd1;
            ps_segs_left = b;
            ps_run       = '0;
            ps_payload   = '0;
            ps_completed = 1'b0;
            ps_phase     = PH_TABLE;
         end
      end else if (ps_phase == PH_TABLE) begin
         lace_open = (b == LACING_MAX);
         ps_run = ps_run + 17'(b);
         if (ps_segs_left != 0)
            ps_segs_left = ps_segs_left - 8'd1;
         if (!lace_open || ps_segs_left == 0) begin
            // The payload starts right after the rest of the lacing table.
            pos = 64'(here) + 64'd1 + 64'(ps_segs_left) + 64'(ps_payload);
            wrapped = pos[POSITION_BITS-1:0];
            push_result(KIND_PACKET, 1'b0, OUT_POS_BITS'(wrapped), ps_run[15:0], lace_open);
            if (!lace_open)
               ps_completed = 1'b1;
            ps_payload = ps_payload + ps_run;
            ps_run = '0;
         end
         if (ps_segs_left == 0) begin
            ok = ps_granule[63] ? lace_open : ps_completed;
            if (!ok) begin
               push_result(KIND_GRANULE, 1'b0, '0, '0, 1'b0);
               ps_halted = 1'b1;
            end else begin
               push_result(KIND_PAGE, !lace_open, '0, '0, 1'b0);
               ps_open_packet = lace_open;
               if (ps_payload != 0) begin
                  ps_skip  = ps_payload;
                  ps_phase = PH_SKIP;
               end else begin
                  clear_page_state();
               end
            end
         end
      end else begin
         if (ps_skip != 0)
            ps_skip = ps_skip - 17'd1;
         if (ps_skip == 0)
            clear_page_state();
      end

      if (expected_results.size() > before_count)
         expected_results[expected_results.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result of kind %0d with nothing outstanding", rsp_kind);
         failures++;
         return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      check_field("kind", 64'(want.kind), 64'(rsp_kind));
      check_field("granule", want.granule, rsp_granule);
      check_field("serial_number", 64'(want.serial_number), 64'(rsp_serial_number));
      check_field("sequence_number", 64'(want.sequence_number), 64'(rsp_sequence_number));
      check_field("page_crc", 64'(want.page_crc), 64'(rsp_page_crc));
      check_field("header_flags", 64'(want.header_flags), 64'(rsp_header_flags));
      check_field("page_done", 64'(want.page_done), 64'(rsp_page_done));
      check_field("packet_position", 64'(want.packet_position), 64'(rsp_packet_position));
      check_field("packet_length", 64'(want.packet_length), 64'(rsp_packet_length));
      check_field("packet_open", 64'(want.packet_open), 64'(rsp_packet_open));
      check_field("last", 64'(want.last), 64'(rsp_last));
      if (rsp_kind == KIND_PAGE)
         pages_seen++;
      else if (rsp_kind == KIND_PACKET)
         packets_seen++;
      else
         faults_seen++;
   endfunction

   // Stream construction.
   function automatic void push_stream_byte(logic [7:0] b);
      pending_bytes.insert(pending_bytes.size(), b);
      bytes_queued++;
   endfunction

   function automatic void push_le(logic [63:0] value, int nbytes);
      for (int i = 0; i < nbytes; i++)
         push_stream_byte(value[8*i +: 8]);
   endfunction

   function automatic void queue_header(logic [7:0] flags, logic [63:0] granule,
                                        logic [31:0] serial, logic [31:0] seq,
                                        logic [31:0] crc, logic [7:0] count);
      foreach (SYNC_BYTES[i])
         push_stream_byte(SYNC_BYTES[i]);
      push_stream_byte(8'($urandom));
      push_stream_byte(flags);
      push_le(granule, 8);
      push_le(64'(serial), 4);
      push_le(64'(seq), 4);
      push_le(64'(crc), 4);
      push_stream_byte(count);
   endfunction

   // A well-formed page: correct sequence and continued flag, random payload.
   function automatic void queue_page(lacing_list_type lace, logic [63:0] granule,
                                      logic [31:0] serial, logic [31:0] crc,
                                      logic [6:0] upper_flags);
      int total;
      total = 0;
      queue_header({upper_flags, gen_open}, granule, serial, gen_sequence, crc,
                   8'(lace.size()));
      foreach (lace[i]) begin
         push_stream_byte(lace[i]);
         total += lace[i];
      end
      repeat (total)
         push_stream_byte(8'($urandom));
      gen_sequence = gen_sequence + 32'd1;
      gen_open = (lace[lace.size() - 1] == LACING_MAX);
   endfunction

   // Picks a granule that agrees with how the page's packets complete.
   function automatic logic [63:0] pick_granule(lacing_list_type lace);
      logic ends_open;
      logic any_done;
      logic [63:0] g;
      ends_open = (lace[lace.size() - 1] == LACING_MAX);
      any_done = 1'b0;
      foreach (lace[i])
         if (lace[i] != LACING_MAX)
            any_done = 1'b1;
      g = {32'($urandom), 32'($urandom)};
      if (ends_open && (!any_done || $urandom_range(1) == 0)) begin
         if ($urandom_range(2) == 0)
            g = '1;
         g[63] = 1'b1;
      end else begin
         case ($urandom_range(3))
            0: g = '0;
            1: g = 64'h7FFF_FFFF_FFFF_FFFF;
            default: g[63] = 1'b0;
         endcase
      end
      return g;
   endfunction

   function automatic lacing_list_type random_lacing();
      lacing_list_type lace;
      int nseg;
      int r;
      nseg = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 4);
      repeat (nseg) begin
         r = $urandom_range(99);
         if (r < 1)
            lace.insert(lace.size(), LACING_MAX);
         else if (r < 15)
            lace.insert(lace.size(), 8'd0);
         else
            lace.insert(lace.size(), 8'($urandom_range(1, 6)));
      end
      // Some pages leave their last packet open for the next page.
      if ($urandom_range(99) < 4)
         lace[nseg - 1] = LACING_MAX;
      return lace;
   endfunction

   function automatic void queue_random_page();
      lacing_list_type lace;
      lace = random_lacing();
      queue_page(lace, pick_granule(lace), $urandom, $urandom, 7'($urandom));
   endfunction

   // A broken page that halts the parser, followed by bytes it must ignore.
   function automatic void queue_fault();
      lacing_list_type lace;
      logic [7:0]      bad;
      logic [63:0]     g;
      int              k;
      fault_kind = FAULT_KINDS[$urandom_range(4)];
      g = {32'($urandom), 32'($urandom)};
      case (fault_kind)
         KIND_BAD_CAPTURE: begin
            k = $urandom_range(3);
            for (int i = 0; i < k; i++)
               push_stream_byte(SYNC_BYTES[i]);
            do
               bad = 8'($urandom);
            while (bad == SYNC_BYTES[k]);
            push_stream_byte(bad);
         end
         KIND_ZERO_SEGS: begin
            queue_header({7'($urandom), gen_open}, g, $urandom, gen_sequence, $urandom, 8'd0);
         end
         KIND_BAD_SEQUENCE: begin
            queue_header({7'($urandom), gen_open}, g, $urandom,
                         gen_sequence ^ (32'($urandom) | 32'd1), $urandom,
                         8'($urandom_range(1, 255)));
         end
         KIND_BAD_CONT: begin
            queue_header({7'($urandom), ~gen_open}, g, $urandom, gen_sequence, $urandom,
                         8'($urandom_range(1, 255)));
         end
         default: begin
            // Either a nonnegative granule with nothing completed, or a
            // negative one on a page whose last packet closes.
            k = $urandom_range(1, 3);
            if ($urandom_range(1) == 0) begin
               g[63] = 1'b0;
               repeat (k)
                  lace.insert(lace.size(), LACING_MAX);
            end else begin
               g[63] = 1'b1;
               repeat (k - 1)
                  lace.insert(lace.size(), 8'($urandom));
               lace.insert(lace.size(), 8'($urandom_range(254)));
            end
            queue_header({7'($urandom), gen_open}, g, $urandom, gen_sequence, $urandom,
                         8'(lace.size()));
            foreach (lace[i])
               push_stream_byte(lace[i]);
         end
      endcase
      repeat (16)
         push_stream_byte(8'($urandom));
   endfunction

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // Byte driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_stream_byte <= 8'd0;
      end else if (!req_valid || req_ready) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_stream_byte <= pending_bytes[0];
            pending_bytes.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Result monitor, prediction and watchdog.
   always @(posedge clock) begin
      if (reset) begin
         reset_parser_state();
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_result();
         if (req_valid && req_ready) begin
            parse_byte(req_stream_byte);
            bytes_accepted++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding",
                     expected_results.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      lacing_list_type lace;
      int unsigned     target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pages: empty payload, field extremes, and a packet left
      // open at the end of one page and closed on the next.
      lace = '{8'd0};
      queue_page(lace, 64'd0, 32'd0, 32'd0, 7'd0);
      lace = '{8'd5, LACING_MAX};
      queue_page(lace, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
      lace = '{8'd2};
      queue_page(lace, 64'h7FFF_FFFF_FFFF_FFFF, $urandom, $urandom, 7'h02);
      wait_drained();

      for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
         case (phase_idx)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 75; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 75; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         target = bytes_queued + PHASE_BYTES;
         while (bytes_queued < target)
            queue_random_page();
         if (phase_idx == 3)
            queue_fault();
         // No further pages are queued until every pending byte and outstanding result has drained.
         wait_drained();
         repeat (5) @(negedge clock);
      end

      repeat (20) @(posedge clock);
      $display("Parsed %0d stream bytes: %0d page headers, %0d packet descriptors.",
               bytes_accepted, pages_seen, packets_seen);
      $display("Closing fault of kind %0d injected, %0d fault result(s) observed.",
               fault_kind, faults_seen);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/oggphp_pkg.sv
hw/rtl/oggphp_parser.sv
hw/rtl/oggphp_fifo.sv
hw/rtl/ogg_page_header_parser_top.sv
tb/sv/tb_top.sv
